/* rtl/pagerank_vertex_update_macros.svh */
// Assertion macros shared by the PageRank vertex update RTL.
`ifndef PAGERANK_VERTEX_UPDATE_MACROS_SVH
`define PAGERANK_VERTEX_UPDATE_MACROS_SVH

`ifndef SYNTHESIS

// Checked property with reset masking.
`define PRVU_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds while reset is applied.
`define PRVU_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PRVU_ASSERT(label, clk, rst, prop, msg)
`define PRVU_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

/* rtl/prvu_pkg.sv */
// Shared widths, constants and types for the PageRank vertex update block.
`default_nettype none

package prvu_pkg;

  localparam int RANK_W  = 32;
  localparam int DEG_W   = 24;
  localparam int SUM_W   = 48;
  localparam int FRAC_W  = 24;
  localparam int ALPHA_W = 25;
  localparam int THR_W   = 32;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Width of one partial product of the shared multiplier: upper sum half times weight.
  localparam int PROD_W  = (SUM_W - FRAC_W) + ALPHA_W;

  // The divider retires one quotient bit per cycle.
  localparam int DIV_STEPS = RANK_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [ALPHA_W-1:0] Q_ONE        = 25'h100_0000;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 25'd2516582;
  localparam logic [THR_W-1:0]   THRESH_RESET = 32'd16777;
  localparam logic [SUM_W-1:0]   SUM_MAX      = {SUM_W{1'b1}};
  localparam logic [RANK_W-1:0]  RANK_MAX     = {RANK_W{1'b1}};

  typedef enum logic [0:0] {
    REG_ALPHA,
    REG_THRESHOLD
  } reg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_ACCUM,
    ST_SCALE,
    ST_RESULT
  } state_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_MUL_LO,
    SC_MUL_HI,
    SC_ADD
  } scale_step_t;

endpackage

`default_nettype wire

/* rtl/prvu_in_if.sv */
// Neighbor item channel of the PageRank vertex update block.
`default_nettype none

interface prvu_in_if;
  import prvu_pkg::*;

  logic               valid;
  logic               ready;
  logic [RANK_W-1:0]  neighbor_rank;
  logic [DEG_W-1:0]   neighbor_degree;
  logic               contributes;
  logic [RANK_W-1:0]  old_rank;
  logic               last_neighbor;

  modport source (
    output valid, neighbor_rank, neighbor_degree, contributes, old_rank, last_neighbor,
    input  ready
  );

  modport sink (
    input  valid, neighbor_rank, neighbor_degree, contributes, old_rank, last_neighbor,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/prvu_out_if.sv */
// Result channel of the PageRank vertex update block.
`default_nettype none

interface prvu_out_if;
  import prvu_pkg::*;

  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] new_rank;
  logic [RANK_W-1:0] rank_change;
  logic              requeue;
  logic              zero_degree_seen;

  modport source (
    output valid, new_rank, rank_change, requeue, zero_degree_seen,
    input  ready
  );

  modport sink (
    input  valid, new_rank, rank_change, requeue, zero_degree_seen,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/pagerank_vertex_update.sv */
// Top level of the pull-style PageRank vertex update block.
//
// Usage: neighbor items arrive on the "neighbor" channel (valid/ready), one per
// in-neighbor of the vertex being updated. A transfer with contributes set and a
// nonzero degree adds floor(rank / degree) to a 48-bit saturating accumulator; a
// contributing item with degree zero adds nothing and marks the vertex. The item
// with last_neighbor set closes the vertex: one result transfer then carries the
// damped rank, its absolute change from old_rank, the requeue decision and the
// zero-degree mark. Items not marked last produce no result.
// Sequence: a contributing item holds the block after its transfer for the 32
// divider steps, the divider handoff and the accumulate; an item that adds
// nothing goes straight to the accumulate. A last item then adds the shared
// multiplier's two passes, the final add and the change compare before its
// result is offered. ready is high only while the sequencer idles.
// Reset (synchronous, rst high) clears the accumulator, the mark and the output
// valid flag and loads the default alpha and threshold. A stalled receiver keeps
// the result in the output register; the block still takes further items and
// only waits if a second result is ready before the first has been taken.
// Configuration goes through the APB port: alpha at byte 0, threshold at byte 4.
`default_nettype none
`include "pagerank_vertex_update_macros.svh"

module pagerank_vertex_update (
  input  logic                          clk,
  input  logic                          rst,
  prvu_in_if.sink                       neighbor,
  prvu_out_if.source                    result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prvu_pkg::PADDR_W-1:0]  paddr,
  input  logic [prvu_pkg::PDATA_W-1:0]  pwdata,
  output logic [prvu_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import prvu_pkg::*;

  // Sequencer state.
  state_t state;
  state_t state_next;

  // Configuration registers.
  logic [ALPHA_W-1:0] alpha;
  logic [THR_W-1:0]   threshold;

  // Per-vertex accumulation state.
  logic [SUM_W-1:0]  partial_sum;
  logic              zflag;

  // The item now being worked on.
  logic              last_q;
  logic              add_en;
  logic [RANK_W-1:0] old_q;

  // Output register.
  logic              res_valid;
  logic [RANK_W-1:0] res_rank;
  logic [RANK_W-1:0] res_change;
  logic              res_requeue;
  logic              res_zero;
  logic              zero_q;

  logic accept;
  logic cfg_write;
  logic div_start;
  logic scl_start;
  logic load_result;

  logic [RANK_W-1:0] quotient;
  logic [RANK_W-1:0] scaled;
  unit_status_t      div_stat;
  unit_status_t      scl_stat;

  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum_next;
  logic [RANK_W-1:0] change;
  logic              nonzero_deg;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha     <= ALPHA_RESET;
      threshold <= THRESH_RESET;
    end else if (cfg_write) begin
      case (reg_idx_t'(paddr[2]))
        REG_ALPHA:     alpha     <= pwdata[ALPHA_W-1:0];
        REG_THRESHOLD: threshold <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_ALPHA:     prdata = PDATA_W'(alpha);
      REG_THRESHOLD: prdata = PDATA_W'(threshold);
      default:       prdata = '0;
    endcase
  end

  assign accept      = neighbor.valid && neighbor.ready;
  assign nonzero_deg = |neighbor.neighbor_degree;

  // Sequencer: one item at a time, the divider and scaler are started from here.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    neighbor.ready = 1'b0;
    div_start      = 1'b0;
    scl_start      = 1'b0;
    load_result    = 1'b0;
    case (state)
      ST_IDLE: begin
        neighbor.ready = 1'b1;
        if (neighbor.valid) begin
          div_start  = neighbor.contributes && nonzero_deg;
          state_next = div_start ? ST_DIVIDE : ST_ACCUM;
        end
      end
      ST_DIVIDE: begin
        if (div_stat.done) state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        if (last_q) begin
          scl_start  = 1'b1;
          state_next = ST_SCALE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCALE: begin
        if (scl_stat.done) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        // The previous result must have left the output register first.
        if (!res_valid || result.ready) begin
          load_result = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  prvu_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (neighbor.neighbor_rank),
    .divisor  (neighbor.neighbor_degree),
    .quotient (quotient),
    .status   (div_stat)
  );

  // Saturating accumulate of the quotient; the scaler samples the updated sum.
  assign sum_wide = (SUM_W+1)'(partial_sum) + (SUM_W+1)'(quotient);
  always_comb begin
    if (!add_en) begin
      sum_next = partial_sum;
    end else if (sum_wide[SUM_W]) begin
      sum_next = SUM_MAX;
    end else begin
      sum_next = sum_wide[SUM_W-1:0];
    end
  end

  prvu_scaler u_scaler (
    .clk       (clk),
    .rst       (rst),
    .start     (scl_start),
    .sum       (sum_next),
    .alpha_cfg (alpha),
    .value     (scaled),
    .status    (scl_stat)
  );

  // Accumulator and zero-degree mark; both are cleared when a vertex closes.
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_sum <= '0;
      zflag       <= 1'b0;
    end else if (accept && neighbor.contributes && !nonzero_deg) begin
      zflag <= 1'b1;
    end else if (state == ST_ACCUM) begin
      if (last_q) begin
        partial_sum <= '0;
        zflag       <= 1'b0;
      end else begin
        partial_sum <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_q <= neighbor.last_neighbor;
      add_en <= neighbor.contributes && nonzero_deg;
      old_q  <= neighbor.old_rank;
    end
    if (state == ST_ACCUM && last_q) begin
      zero_q <= zflag;
    end
  end

  assign change = (scaled >= old_q) ? (scaled - old_q) : (old_q - scaled);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_result) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      res_rank    <= scaled;
      res_change  <= change;
      res_requeue <= change > threshold;
      res_zero    <= zero_q;
    end
  end

  assign result.valid            = res_valid;
  assign result.new_rank         = res_rank;
  assign result.rank_change      = res_change;
  assign result.requeue          = res_requeue;
  assign result.zero_degree_seen = res_zero;

  // The input side only opens while neither shared unit is running.
  `PRVU_ASSERT(a_ready_units_idle, clk, rst, neighbor.ready |-> !div_stat.busy && !scl_stat.busy, "ready while a unit is busy")

  // A divider completion is only expected while the sequencer waits for it.
  `PRVU_ASSERT(a_div_done_state, clk, rst, div_stat.done |-> state == ST_DIVIDE, "divider finished outside the divide state")

  // A scaler completion is only expected while the sequencer waits for it.
  `PRVU_ASSERT(a_scl_done_state, clk, rst, scl_stat.done |-> state == ST_SCALE, "scaler finished outside the scale state")

  // Closing a vertex leaves the accumulator and the mark clear.
  `PRVU_ASSERT_ALWAYS(a_close_clears, clk, (!rst && state == ST_ACCUM && last_q) |=> (partial_sum == '0) && !zflag, "accumulator not cleared after the last item")

endmodule

`default_nettype wire

/* rtl/prvu_divider.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module prvu_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [prvu_pkg::RANK_W-1:0]   dividend,
  input  logic [prvu_pkg::DEG_W-1:0]    divisor,
  output logic [prvu_pkg::RANK_W-1:0]   quotient,
  output prvu_pkg::unit_status_t        status
);
  import prvu_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] count;
  logic [RANK_W-1:0] quo;
  logic [DEG_W-1:0]  rem;
  logic [DEG_W-1:0]  dvs;

  logic [DEG_W:0] trial;
  logic [DEG_W:0] diff;
  logic           fits;

  // The partial remainder stays below the divisor, so the shifted value fits in DEG_W+1 bits.
  assign trial = {rem, quo[RANK_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[DEG_W-1:0] : trial[DEG_W-1:0];
      quo <= {quo[RANK_W-2:0], fits};
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule

`default_nettype wire

/* rtl/prvu_scaler.sv */
// Damping stage: (1 - alpha) * sum + alpha on one shared 24x25 multiplier.
`default_nettype none

module prvu_scaler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [prvu_pkg::SUM_W-1:0]    sum,
  input  logic [prvu_pkg::ALPHA_W-1:0]  alpha_cfg,
  output logic [prvu_pkg::RANK_W-1:0]   value,
  output prvu_pkg::unit_status_t        status
);
  import prvu_pkg::*;

  scale_step_t step;
  scale_step_t step_next;
  logic        done;

  logic [SUM_W-1:0]         sum_q;
  logic [ALPHA_W-1:0]       alpha_q;
  logic [ALPHA_W-1:0]       weight_q;
  logic [ALPHA_W-1:0]       alpha_c;
  logic [SUM_W-FRAC_W-1:0]  mul_a;
  logic [PROD_W-1:0]        product;
  logic [ALPHA_W-1:0]       prod_lo;
  logic [PROD_W-1:0]        prod_hi;
  logic [PROD_W:0]          total;

  // Alpha above one counts as one, which weights the neighbor sum by zero.
  assign alpha_c = (alpha_cfg > Q_ONE) ? Q_ONE : alpha_cfg;

  assign mul_a   = (step == SC_MUL_LO) ? (SUM_W-FRAC_W)'(sum_q[FRAC_W-1:0])
                                       : sum_q[SUM_W-1:FRAC_W];
  assign product = PROD_W'(mul_a) * PROD_W'(weight_q);
  assign total   = (PROD_W+1)'(prod_hi) + (PROD_W+1)'(prod_lo) + (PROD_W+1)'(alpha_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= SC_IDLE;
      done <= 1'b0;
    end else begin
      step <= step_next;
      done <= (step == SC_ADD);
    end
  end

  always_comb begin
    step_next = step;
    case (step)
      SC_IDLE:   if (start) step_next = SC_MUL_LO;
      SC_MUL_LO: step_next = SC_MUL_HI;
      SC_MUL_HI: step_next = SC_ADD;
      SC_ADD:    step_next = SC_IDLE;
      default:   step_next = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start && step == SC_IDLE) begin
      sum_q    <= sum;
      alpha_q  <= alpha_c;
      weight_q <= Q_ONE - alpha_c;
    end
    if (step == SC_MUL_LO) begin
      prod_lo <= product[PROD_W-1:FRAC_W];
    end
    if (step == SC_MUL_HI) begin
      prod_hi <= product;
    end
    if (step == SC_ADD) begin
      value <= (|total[PROD_W:RANK_W]) ? RANK_MAX : total[RANK_W-1:0];
    end
  end

  assign status.busy = (step != SC_IDLE);
  assign status.done = done;

endmodule

`default_nettype wire

/* bench/pagerank_vertex_update_tb.sv */
// Self-checking testbench for the pull-style PageRank vertex update block.
`default_nettype none

module pagerank_vertex_update_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prvu_pkg::*;

  // Watchdog limit, set well above what a slow correct run needs.
  localparam int CYCLE_LIMIT = 500_000;
  // Wait in settle() after the last owed result, for an item that owes none to finish.
  localparam int DRAIN_CYCLES = 45;
  localparam int PHASE_ITEMS = 125;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [DEG_W-1:0]  degree;
    logic              contributes;
    logic [RANK_W-1:0] old_rank;
    logic              last;
  } neighbor_t;

  typedef struct packed {
    logic [RANK_W-1:0] new_rank;
    logic [RANK_W-1:0] change;
    logic              requeue;
    logic              zero_degree;
  } outcome_t;

  // One row of the directed sequence. When set_cfg is high, the block is drained and both
  // registers are written before the item goes out. When typed is high, the result is the
  // one written in the row rather than the one the predictor works out.
  typedef struct packed {
    logic               set_cfg;
    logic [ALPHA_W-1:0] alpha;
    logic [THR_W-1:0]   thresh;
    neighbor_t          item;
    logic               typed;
    outcome_t           want;
  } plan_row_t;

  localparam int PLAN_LEN = 17;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // Reset settings: alpha 0.15, threshold about 0.001.
    // An empty vertex right after reset gives new_rank = alpha.
    '{1'b0, '0, '0, '{32'd0, 24'd0, 1'b0, 32'd0, 1'b1},
      1'b1, '{32'd2516582, 32'd2516582, 1'b1, 1'b0}},
    // A contributing neighbor of degree zero adds nothing but marks the vertex.
    '{1'b0, '0, '0, '{32'hFFFF_FFFF, 24'd0, 1'b1, 32'd2516582, 1'b1},
      1'b1, '{32'd2516582, 32'd0, 1'b0, 1'b1}},
    // A neighbor that does not contribute never marks, even with degree zero.
    '{1'b0, '0, '0, '{32'hFFFF_FFFF, 24'd0, 1'b0, 32'd0, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '0, '{32'd0, 24'd0, 1'b0, 32'hFFFF_FFFF, 1'b1},
      1'b1, '{32'd2516582, 32'd4292450713, 1'b1, 1'b0}},
    // Ordinary accumulation, including the largest degree.
    '{1'b0, '0, '0, '{32'h0100_0000, 24'd3, 1'b1, 32'd0, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '0, '{32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1, 32'd0, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '0, '{32'h0100_0000, 24'd1, 1'b1, 32'd0, 1'b1}, 1'b0, '0},
    // Alpha zero and threshold zero: two full ranks overflow the result.
    '{1'b1, 25'd0, 32'd0, '{32'hFFFF_FFFF, 24'd1, 1'b1, 32'd0, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '0, '{32'hFFFF_FFFF, 24'd1, 1'b1, 32'd0, 1'b1},
      1'b1, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0}},
    // Truncating division; a change of zero is not above a threshold of zero.
    '{1'b0, '0, '0, '{32'd5, 24'd2, 1'b1, 32'd2, 1'b1},
      1'b1, '{32'd2, 32'd0, 1'b0, 1'b0}},
    '{1'b0, '0, '0, '{32'd0, 24'd0, 1'b1, 32'd1, 1'b1},
      1'b1, '{32'd0, 32'd1, 1'b1, 1'b1}},
    // Alpha at its largest code is taken as one, so the rank is 1.0 whatever the sum.
    '{1'b1, 25'h1FF_FFFF, 32'hFFFF_FFFF, '{32'hFFFF_FFFF, 24'd1, 1'b1, 32'd0, 1'b0},
      1'b0, '0},
    '{1'b0, '0, '0, '{32'hFFFF_FFFF, 24'd1, 1'b1, 32'hFFFF_FFFF, 1'b1},
      1'b1, '{32'd16777216, 32'd4278190079, 1'b0, 1'b0}},
    // Alpha exactly one; a change one above the threshold requeues.
    '{1'b1, 25'h100_0000, 32'd16777215, '{32'd0, 24'd0, 1'b0, 32'd0, 1'b1},
      1'b1, '{32'd16777216, 32'd16777216, 1'b1, 1'b0}},
    // Alpha just below one leaves a weight of a single LSB.
    '{1'b1, 25'h0FF_FFFF, 32'd16777, '{32'hFFFF_FFFF, 24'd1, 1'b1, 32'hFFFF_FFFF, 1'b1},
      1'b0, '0},
    '{1'b0, '0, '0, '{32'h8000_0000, 24'h80_0000, 1'b1, 32'd0, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '0, '{32'h5555_5555, 24'hAA_AAAA, 1'b1, 32'h5555_5555, 1'b1}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  prvu_in_if  nbr ();
  prvu_out_if res ();

  // The receiver's ready comes from a plain variable so that it is known from time zero.
  logic take_ok = 1'b0;
  assign res.ready = take_ok;

  pagerank_vertex_update i_dut (
    .clk     (clk),
    .rst     (rst),
    .neighbor(nbr),
    .result  (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: its own copy of the registers, the accumulator and the zero-degree mark.
  logic [ALPHA_W-1:0] alpha_reg     = ALPHA_RESET;
  logic [THR_W-1:0]   threshold_reg = THRESH_RESET;
  logic [SUM_W-1:0]   sum_acc       = '0;
  logic               zero_deg_acc  = 1'b0;

  // Results the block still owes, oldest first.
  outcome_t ranks_due [$];

  int mismatches    = 0;
  int results_taken = 0;
  int cycles        = 0;
  int idle_pct      = 0;
  int stall_pct     = 0;

  task automatic flag_mismatch(input string what);
    $display("[%0d] result %0d: %s", cycles, results_taken, what);
    mismatches++;
  endtask

  // Adds one neighbor's share, floor(rank / degree), with saturation of the 48-bit sum.
  function automatic logic [SUM_W-1:0] add_share(input logic [SUM_W-1:0] acc,
                                                  input neighbor_t n);
    logic [SUM_W:0] total;
    if (!n.contributes || n.degree == '0) return acc;
    total = {1'b0, acc} + (SUM_W + 1)'(n.rank / n.degree);
    return total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
  endfunction

  // (1 - alpha) * sum + alpha with alpha clipped to one; the product truncates exactly,
  // taken as two partial products over the upper and lower halves of the sum.
  function automatic logic [RANK_W-1:0] damped_rank(input logic [SUM_W-1:0] acc);
    logic [ALPHA_W-1:0] eff_alpha;
    logic [ALPHA_W-1:0] weight;
    logic [63:0]        value;
    eff_alpha = (alpha_reg > Q_ONE) ? Q_ONE : alpha_reg;
    weight    = Q_ONE - eff_alpha;
    value     = 64'(acc[SUM_W-1:FRAC_W]) * 64'(weight)
              + ((64'(acc[FRAC_W-1:0]) * 64'(weight)) >> FRAC_W)
              + 64'(eff_alpha);
    return (value > 64'(RANK_MAX)) ? RANK_MAX : value[RANK_W-1:0];
  endfunction

  // Advances the predictor by one accepted neighbor and queues the result a last item owes.
  function automatic void fold_neighbor(input neighbor_t n);
    outcome_t o;
    sum_acc = add_share(sum_acc, n);
    if (n.contributes && n.degree == '0) zero_deg_acc = 1'b1;
    if (n.last) begin
      o.new_rank    = damped_rank(sum_acc);
      o.change      = (o.new_rank >= n.old_rank) ? o.new_rank - n.old_rank
                                                 : n.old_rank - o.new_rank;
      o.requeue     = o.change > threshold_reg;
      o.zero_degree = zero_deg_acc;
      ranks_due     = {ranks_due, o};
      sum_acc      = '0;
      zero_deg_acc = 1'b0;
    end
  endfunction

  // Offers one neighbor after a random number of idle cycles and returns at the edge of its
  // transfer. valid is left high so that a following item can go out back to back.
  task automatic push_neighbor(input neighbor_t n);
    while ($urandom_range(0, 99) < idle_pct) begin
      nbr.valid <= 1'b0;
      @(posedge clk);
    end
    nbr.valid           <= 1'b1;
    nbr.neighbor_rank   <= n.rank;
    nbr.neighbor_degree <= n.degree;
    nbr.contributes     <= n.contributes;
    nbr.old_rank        <= n.old_rank;
    nbr.last_neighbor   <= n.last;
    do @(posedge clk); while (!nbr.ready);
    fold_neighbor(n);
  endtask

  // Withdraws valid, waits for every owed result, then lets the block finish any item that
  // owes none, so that the registers can be changed safely.
  task automatic settle();
    nbr.valid <= 1'b0;
    while (ranks_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: a setup cycle, then an access cycle that completes when pready is high.
  // psel and penable then drop before the task returns, so that a second write starts with a fresh setup cycle.
  task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ALPHA:     alpha_reg     = value[ALPHA_W-1:0];
      REG_THRESHOLD: threshold_reg = value[THR_W-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: ready is redrawn every cycle, and each result transfer is checked field by
  // field against the oldest owed result.
  always @(posedge clk) begin : take_results
    outcome_t want;
    take_ok <= !rst && ($urandom_range(0, 99) >= stall_pct);
    if (!rst && res.valid && res.ready) begin
      results_taken++;
      if (ranks_due.size() == 0) begin
        flag_mismatch("result transfer with nothing owed");
      end else begin
        want = ranks_due[0];
        ranks_due.delete(0);
        if (res.new_rank !== want.new_rank)
          flag_mismatch($sformatf("new_rank 0x%08h, expected 0x%08h",
                                  res.new_rank, want.new_rank));
        if (res.rank_change !== want.change)
          flag_mismatch($sformatf("rank_change 0x%08h, expected 0x%08h",
                                  res.rank_change, want.change));
        if (res.requeue !== want.requeue)
          flag_mismatch($sformatf("requeue %b, expected %b", res.requeue, want.requeue));
        if (res.zero_degree_seen !== want.zero_degree)
          flag_mismatch($sformatf("zero_degree_seen %b, expected %b",
                                  res.zero_degree_seen, want.zero_degree));
      end
    end
  end

  // Watchdog: a run that has not ended by now is hung or lost results.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    neighbor_t         item;
    logic [RANK_W-1:0] near;
    logic [RANK_W-1:0] gap;
    int                fan_in;
    int                pick;
    int                counted;

    nbr.valid           <= 1'b0;
    nbr.neighbor_rank   <= '0;
    nbr.neighbor_degree <= '0;
    nbr.contributes     <= 1'b0;
    nbr.old_rank        <= '0;
    nbr.last_neighbor   <= 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, with both sides always willing. The first rows rely on the reset
    // values of alpha and threshold.
    foreach (PLAN[i]) begin
      if (PLAN[i].set_cfg) begin
        settle();
        write_reg(REG_ALPHA, PDATA_W'(PLAN[i].alpha));
        write_reg(REG_THRESHOLD, PLAN[i].thresh);
      end
      push_neighbor(PLAN[i].item);
      if (PLAN[i].typed) ranks_due[ranks_due.size() - 1] = PLAN[i].want;
    end

    // Random part: four phases, each with its own idling pattern and register settings.
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          write_reg(REG_ALPHA, PDATA_W'($urandom_range(0, Q_ONE)));
          write_reg(REG_THRESHOLD, $urandom_range(0, 50000));
        end
        1: begin
          idle_pct = 82;
          stall_pct = 0;
          write_reg(REG_ALPHA, '0);
          write_reg(REG_THRESHOLD, $urandom);
        end
        2: begin
          // Any 25-bit alpha, so about half the vertices see alpha above one.
          idle_pct = 0;
          stall_pct = 82;
          write_reg(REG_ALPHA, PDATA_W'($urandom_range(0, 25'h1FF_FFFF)));
          write_reg(REG_THRESHOLD, $urandom_range(0, 50000));
        end
        default: begin
          idle_pct = 20;
          stall_pct = 20;
          write_reg(REG_ALPHA, PDATA_W'($urandom_range(0, Q_ONE)));
          write_reg(REG_THRESHOLD, $urandom_range(0, 1 << 20));
        end
      endcase

      // Vertices of one to six neighbors. Most neighbors contribute, with small degrees so
      // the sum stays meaningful; some carry full-width degrees, a few degree zero, and a
      // few are empty list items.
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        fan_in = $urandom_range(1, 6);
        for (int k = 0; k < fan_in; k++) begin
          item.rank = $urandom_range(0, 1) ? RANK_W'($urandom)
                                           : RANK_W'($urandom_range(0, 32'h0400_0000));
          pick = $urandom_range(0, 99);
          item.degree = (pick < 5)  ? '0 :
                        (pick < 65) ? DEG_W'($urandom_range(1, 16)) : DEG_W'($urandom);
          item.contributes = $urandom_range(0, 99) < 90;
          item.last = (k == fan_in - 1);
          item.old_rank = $urandom;
          // Half the vertices get an old rank close to the new one, often exactly at the
          // threshold or one past it, so that requeue goes both ways.
          if (item.last && $urandom_range(0, 1) == 1) begin
            near = damped_rank(add_share(sum_acc, item));
            pick = $urandom_range(0, 2);
            gap = (pick == 0) ? threshold_reg :
                  (pick == 1) ? threshold_reg + 1'b1 : RANK_W'($urandom_range(0, 40000));
            item.old_rank = (near >= gap) ? near - gap : near + gap;
          end
          push_neighbor(item);
          if (item.contributes || item.last) counted++;
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* pagerank_vertex_update.f */
+incdir+rtl
rtl/prvu_pkg.sv
rtl/prvu_in_if.sv
rtl/prvu_out_if.sv
rtl/prvu_divider.sv
rtl/prvu_scaler.sv
rtl/pagerank_vertex_update.sv
bench/pagerank_vertex_update_tb.sv
